@@ hdl/pkc_pkg.sv @@
// ----------------------------------------------------------------------------
// pkc_pkg - shared types and constants for the kernel convolution block
// Field widths, command and register codes, sequencer states, MAC control.
// ----------------------------------------------------------------------------
package pkc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_KERNEL_DEF = 9;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 7;
  localparam int COEFF_W  = 24;
  localparam int SAMPLE_W = 8;
  localparam int WORD_W   = 3 * SAMPLE_W;
  localparam int RES_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = COEFF_W + SAMPLE_W + 1;
  localparam int KSZ_W    = 4;
  localparam int HGT_W    = 16;
  localparam int WID_W    = 11;
  localparam int ROW_W    = HGT_W + 1;   // rows run a few past the image on drain
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_KSIZE  = 2'd2,
    CFG_COLOUR = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_DUE,
    S_CHK,
    S_TAP,
    S_FLUSH,
    S_SAT
  } state_t;

  typedef struct packed {
    logic clear;   // zero the accumulators
    logic valid;   // tap data on coef/word is live
  } mac_ctl_t;

endpackage

@@ hdl/pkc_mac.sv @@
// ----------------------------------------------------------------------------
// pkc_mac - shared three-channel multiply-accumulate unit
// One tap per cycle: registered products, then accumulate; saturating output.
// ----------------------------------------------------------------------------
module pkc_mac #(
  parameter int ACC_W = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pkc_pkg::mac_ctl_t                    ctl,
  input  logic signed [pkc_pkg::COEFF_W-1:0]   coef,
  input  logic        [pkc_pkg::WORD_W-1:0]    word,
  output logic        [3*pkc_pkg::RES_W-1:0]   res
);

  logic signed [pkc_pkg::PROD_W-1:0] prod_r [3];
  logic signed [ACC_W-1:0]           acc_r  [3];
  logic signed [ACC_W-1:0]           adj    [3];
  logic signed [ACC_W-1:0]           quo    [3];
  logic                              v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= coef * $signed({1'b0, word[c*pkc_pkg::SAMPLE_W +: pkc_pkg::SAMPLE_W]});
      if (ctl.clear) begin
        acc_r[c] <= '0;
      end else if (v2_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
  end

  // divide by 2^16 toward zero, then clamp
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      adj[c] = acc_r[c] + (acc_r[c][ACC_W-1] ? ACC_W'((1 << pkc_pkg::FRAC_W) - 1) : '0);
      quo[c] = adj[c] >>> pkc_pkg::FRAC_W;
      if (quo[c] > pkc_pkg::SAT_MAX) begin
        res[c*pkc_pkg::RES_W +: pkc_pkg::RES_W] = pkc_pkg::RES_W'(pkc_pkg::SAT_MAX);
      end else if (quo[c] < pkc_pkg::SAT_MIN) begin
        res[c*pkc_pkg::RES_W +: pkc_pkg::RES_W] = pkc_pkg::RES_W'(pkc_pkg::SAT_MIN);
      end else begin
        res[c*pkc_pkg::RES_W +: pkc_pkg::RES_W] = quo[c][pkc_pkg::RES_W-1:0];
      end
    end
  end

endmodule

@@ hdl/pixel_kernel_convolution.sv @@
// ----------------------------------------------------------------------------
// pixel_kernel_convolution - streaming 2D convolution, square odd kernel
// Coefficient store, row ring, tap sequencer and one shared MAC unit.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_*: plain write port, to be written only while idle; the block itself
//    does not enforce this. Index 0 width, 1 height, 2 kernel side, 3 colour mode.
//  - in_*: tuser holds the command. A load word writes one coefficient;
//    pixel and drain words each take one raster position in the row ring.
//  - out_*: one word per output position, in raster order, once the
//    neighbourhood has arrived; tlast marks the image's last pixel.
// Sequencing (k = effective kernel side):
//  - load: written from the idle state.  Pixel/drain: write, due and check states.
//  - pixel/drain with a result: then k*k taps, a MAC flush and saturation; the
//    shared MAC takes one tap a cycle, so k*k taps dominate.
//  - in_tready is high only in the idle state; a result sits in the output
//    register while the next word is taken.
// Reset: counters and ring pointers clear, registers return to 1024 x 1024,
//  k = 3, colour. Stores are not cleared: load all k*k coefficients first.
// Stall: with a result still held, the sequencer waits before loading the
//  next one; nothing is dropped.
// ----------------------------------------------------------------------------
module pixel_kernel_convolution #(
  parameter int MAX_WIDTH  = pkc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = pkc_pkg::MAX_KERNEL_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [pkc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pkc_pkg::CFG_DAT_W-1:0]    cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // coeff_index[6:0], coeff_value[30:7], blue[38:31], green[46:39],
  // red[54:47], zero[55]
  input  logic [55:0]                      in_tdata,
  // command[1:0]
  input  logic [pkc_pkg::CMD_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_blue[15:0], out_green[31:16], out_red[47:32]
  output logic [47:0]                      out_tdata,
  output logic                             out_tlast   // frame_end
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int ROW_SLOTS  = 2 * MAX_KERNEL;
  localparam int SW         = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int MEM_DEPTH  = ROW_SLOTS * MAX_WIDTH;
  localparam int AW         = $clog2(MEM_DEPTH);
  localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int CIW        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int RW         = pkc_pkg::ROW_W;
  localparam int POS_W      = RW + CW + 2;
  localparam int XW         = CW + 5;
  localparam int DW         = SW + 5;
  localparam int ACC_W      = pkc_pkg::PROD_W + $clog2(COEF_DEPTH) + 1;
  localparam int MAC_LAT    = 2;
  localparam int KW         = pkc_pkg::KSZ_W;

  // configuration
  logic [pkc_pkg::WID_W-1:0]  cfg_width_r;
  logic [pkc_pkg::HGT_W-1:0]  cfg_height_r;
  logic [KW-1:0]              cfg_ksize_r;
  logic                       cfg_colour_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= pkc_pkg::WID_W'(1024);
      cfg_height_r <= pkc_pkg::HGT_W'(1024);
      cfg_ksize_r  <= KW'(3);
      cfg_colour_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (pkc_pkg::cfg_idx_t'(cfg_index))
        pkc_pkg::CFG_WIDTH:  cfg_width_r  <= cfg_wdata[pkc_pkg::WID_W-1:0];
        pkc_pkg::CFG_HEIGHT: cfg_height_r <= cfg_wdata[pkc_pkg::HGT_W-1:0];
        pkc_pkg::CFG_KSIZE:  cfg_ksize_r  <= cfg_wdata[KW-1:0];
        pkc_pkg::CFG_COLOUR: cfg_colour_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [CW:0]                w_eff;
  logic [pkc_pkg::HGT_W-1:0]  h_eff;
  logic [KW-1:0]              k_clip, k_eff, r_eff, km1;

  always_comb begin
    if (cfg_width_r == '0)                w_eff = (CW+1)'(1);
    else if (cfg_width_r > MAX_WIDTH)     w_eff = (CW+1)'(MAX_WIDTH);
    else                                  w_eff = (CW+1)'(cfg_width_r);
    h_eff  = (cfg_height_r == '0) ? pkc_pkg::HGT_W'(1) : cfg_height_r;
    k_clip = (cfg_ksize_r > MAX_KERNEL) ? KW'(MAX_KERNEL) : cfg_ksize_r;
    if (k_clip[0])             k_eff = k_clip;
    else if (k_clip == '0)     k_eff = KW'(1);
    else                       k_eff = k_clip - KW'(1);
    r_eff = k_eff >> 1;
    km1   = k_eff - KW'(1);
  end

  // sequencer
  pkc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   in_col_r, out_col_r;
  logic [RW-1:0]   in_row_r, out_row_r;
  logic [SW-1:0]   in_slot_r, out_slot_r;
  logic [pkc_pkg::WORD_W-1:0] word_r;
  logic [POS_W-1:0] cur_r, due_r;
  logic [KW-1:0]   mi_r, ni_r;
  logic [CIW-1:0]  ci_r;
  logic [1:0]      flush_r;
  logic            out_valid_r;

  logic            in_acc, tap_last, frame_last;
  logic            row_wr, cur_ld, due_ld, tap_start, tap_issue, sat_ld;
  pkc_pkg::cmd_t   in_cmd;

  assign in_cmd   = pkc_pkg::cmd_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;
  assign tap_last = (mi_r == km1) && (ni_r == km1);
  assign frame_last = (out_row_r >= RW'(h_eff - pkc_pkg::HGT_W'(1))) &&
                      ((CW+1)'(out_col_r) >= w_eff - (CW+1)'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pkc_pkg::S_IDLE: begin
        if (in_acc && (in_cmd == pkc_pkg::CMD_PIXEL || in_cmd == pkc_pkg::CMD_DRAIN))
          state_nxt = pkc_pkg::S_WRITE;
      end
      pkc_pkg::S_WRITE: state_nxt = pkc_pkg::S_DUE;
      pkc_pkg::S_DUE:   state_nxt = pkc_pkg::S_CHK;
      pkc_pkg::S_CHK: begin
        state_nxt = (cur_r >= due_r) ? pkc_pkg::S_TAP : pkc_pkg::S_IDLE;
      end
      pkc_pkg::S_TAP: begin
        if (tap_last) state_nxt = pkc_pkg::S_FLUSH;
      end
      pkc_pkg::S_FLUSH: begin
        if (flush_r == 2'(MAC_LAT)) state_nxt = pkc_pkg::S_SAT;
      end
      pkc_pkg::S_SAT: begin
        if (sat_ld) state_nxt = pkc_pkg::S_IDLE;
      end
      default: state_nxt = pkc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    row_wr    = 1'b0;
    cur_ld    = 1'b0;
    due_ld    = 1'b0;
    tap_start = 1'b0;
    tap_issue = 1'b0;
    sat_ld    = 1'b0;
    case (state_r)
      pkc_pkg::S_IDLE:  in_tready = 1'b1;
      pkc_pkg::S_WRITE: begin
        row_wr = 1'b1;
        cur_ld = 1'b1;
      end
      pkc_pkg::S_DUE:   due_ld = 1'b1;
      pkc_pkg::S_CHK:   tap_start = (cur_r >= due_r);
      pkc_pkg::S_TAP:   tap_issue = 1'b1;
      pkc_pkg::S_SAT:   sat_ld = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pkc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // tap address generation
  logic signed [RW+1:0] yy;
  logic signed [XW:0]   xx;
  logic signed [DW:0]   dd;
  logic [SW-1:0]        tap_slot;
  logic                 tap_ok;
  logic [AW-1:0]        rd_addr, wr_addr;

  always_comb begin
    yy = $signed({1'b0, (RW+1)'(out_row_r) + (RW+1)'(mi_r)}) -
         $signed({1'b0, (RW+1)'(r_eff)});
    xx = $signed({1'b0, XW'(out_col_r) + XW'(ni_r)}) - $signed({1'b0, XW'(r_eff)});
    dd = $signed({1'b0, DW'(out_slot_r) + DW'(mi_r)}) - $signed({1'b0, DW'(r_eff)});
    if (dd < 0)                  tap_slot = SW'(dd + (DW+1)'(ROW_SLOTS));
    else if (dd >= ROW_SLOTS)    tap_slot = SW'(dd - (DW+1)'(ROW_SLOTS));
    else                         tap_slot = SW'(dd);
    tap_ok  = !yy[RW+1] && (yy[RW:0] < (RW+1)'(h_eff)) &&
              !xx[XW] && (xx[XW-1:0] < XW'(w_eff));
    rd_addr = AW'(tap_slot) * AW'(MAX_WIDTH) + AW'(xx[CW-1:0]);
    wr_addr = AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r);
  end

  // stores
  logic [pkc_pkg::WORD_W-1:0]         row_mem  [MEM_DEPTH];
  logic signed [pkc_pkg::COEFF_W-1:0] coef_mem [COEF_DEPTH];
  logic [pkc_pkg::WORD_W-1:0]         rd_word_r;
  logic signed [pkc_pkg::COEFF_W-1:0] rd_coef_r;
  logic                               v1_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == pkc_pkg::CMD_LOAD && in_tdata[pkc_pkg::IDX_W-1:0] < COEF_DEPTH)
      coef_mem[CIW'(in_tdata[pkc_pkg::IDX_W-1:0])] <= $signed(in_tdata[30:7]);
    if (row_wr)
      row_mem[wr_addr] <= word_r;
    rd_word_r <= row_mem[rd_addr];
    rd_coef_r <= coef_mem[ci_r];
  end

  // counters and datapath registers
  logic [CW:0] in_col_inc, out_col_inc;
  assign in_col_inc  = (CW+1)'(in_col_r) + (CW+1)'(1);
  assign out_col_inc = (CW+1)'(out_col_r) + (CW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slot_r  <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      flush_r     <= '0;
    end else begin
      v1_r <= tap_issue && tap_ok;
      if (cur_ld) begin
        if (in_col_inc >= w_eff) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + RW'(1);
          in_slot_r <= (in_slot_r == SW'(ROW_SLOTS - 1)) ? '0 : in_slot_r + SW'(1);
        end else begin
          in_col_r  <= in_col_inc[CW-1:0];
        end
      end
      if (state_r == pkc_pkg::S_FLUSH) flush_r <= flush_r + 2'd1;
      else                             flush_r <= '0;
      if (sat_ld) begin
        out_valid_r <= 1'b1;
        if (frame_last) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          in_slot_r  <= '0;
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_slot_r <= '0;
        end else if (out_col_inc >= w_eff) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + RW'(1);
          out_slot_r <= (out_slot_r == SW'(ROW_SLOTS - 1)) ? '0 : out_slot_r + SW'(1);
        end else begin
          out_col_r  <= out_col_inc[CW-1:0];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc)
      word_r <= (in_cmd == pkc_pkg::CMD_PIXEL) ? in_tdata[54:31] : '0;
    if (cur_ld)
      cur_r <= POS_W'(in_row_r) * POS_W'(w_eff) + POS_W'(in_col_r);
    if (due_ld)
      due_r <= (POS_W'(out_row_r) + POS_W'(r_eff)) * POS_W'(w_eff) +
               POS_W'(out_col_r) + POS_W'(r_eff);
    if (tap_start) begin
      mi_r <= '0;
      ni_r <= '0;
      ci_r <= '0;
    end else if (tap_issue) begin
      ci_r <= ci_r + CIW'(1);
      if (ni_r == km1) begin
        ni_r <= '0;
        mi_r <= mi_r + KW'(1);
      end else begin
        ni_r <= ni_r + KW'(1);
      end
    end
  end

  // shared MAC
  pkc_pkg::mac_ctl_t           mac_ctl;
  logic [3*pkc_pkg::RES_W-1:0] mac_res;

  assign mac_ctl.clear = tap_start;
  assign mac_ctl.valid = v1_r;

  pkc_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (rd_coef_r),
    .word  (rd_word_r),
    .res   (mac_res)
  );

  // output register
  logic [47:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (sat_ld) begin
      out_data_r[15:0]  <= mac_res[15:0];
      out_data_r[31:16] <= cfg_colour_r ? mac_res[31:16] : '0;
      out_data_r[47:32] <= cfg_colour_r ? mac_res[47:32] : '0;
      out_last_r        <= frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
